>>> hdl/wchs_pkg.sv
// Package: shared types, codes and constants of the wanted-content hash set.
`timescale 1ns / 1ps
`default_nettype none
package wchs_pkg;

  localparam int unsigned OwnerSlotsDef = 8;
  localparam int unsigned WantLimitDef  = 512;

  localparam int unsigned OwnerW    = 8;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned HashRounds = 34;   // 32 hash bytes, size low, size high
  localparam int unsigned ByteRounds = 32;
  localparam int unsigned ModSteps   = 3;    // reciprocal multiply, back-subtract, correct
  localparam int unsigned RndW      = 6;

  localparam logic [KeyW-1:0] FnvBasis = 32'd2166136261;
  localparam logic [KeyW-1:0] FnvPrime = 32'd16777619;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RESOLVE,
    ST_HASH,
    ST_MOD,
    ST_QSLOT,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic resolve;
    logic set_dropped;
    logic set_ovf;
    logic hash_step;
    logic mod_start;
    logic mod_step;
    logic probe_start;
    logic mem_rd;
    logic probe_adv;
    logic insert;
    logic set_wanted;
    logic q_start;
    logic q_next;
    logic sweep_start;
    logic sweep_wr;
    logic slot_clear;
    logic init_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  owner_nz;
    logic  found;
    logic  free_any;
    logic  sel_ovf;
    logic  sel_full;
    logic  hash_done;
    logic  mod_done;
    logic  q_owner_nz;
    logic  q_ovf;
    logic  q_last;
    logic  rd_empty;
    logic  rd_hit;
    logic  n_last;
    logic  sweep_last;
    logic  init_last;
    logic  out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/wchs_ctrl.sv
// Controller: sequences hashing, probing, sweeping and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module wchs_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wchs_pkg::status_t st_i,
  output wchs_pkg::cmd_t    cmd_o
);

  wchs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wchs_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wchs_pkg::ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (st_i.init_last) state_d = wchs_pkg::ST_IDLE;
      end
      wchs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wchs_pkg::ST_RESOLVE;
        end
      end
      wchs_pkg::ST_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        unique case (st_i.kind)
          wchs_pkg::KIND_ADD: begin
            if (!st_i.owner_nz || (!st_i.found && !st_i.free_any)) begin
              cmd_o.set_dropped = 1'b1;
              state_d = wchs_pkg::ST_DONE;
            end else if (st_i.sel_ovf) begin
              state_d = wchs_pkg::ST_DONE;
            end else if (st_i.sel_full) begin
              cmd_o.set_ovf = 1'b1;
              state_d = wchs_pkg::ST_DONE;
            end else begin
              state_d = wchs_pkg::ST_HASH;
            end
          end
          wchs_pkg::KIND_QUERY: begin
            cmd_o.q_start = 1'b1;
            state_d = wchs_pkg::ST_HASH;
          end
          default: begin
            if (st_i.found) begin
              cmd_o.sweep_start = 1'b1;
              state_d = wchs_pkg::ST_SWEEP;
            end else begin
              state_d = wchs_pkg::ST_DONE;
            end
          end
        endcase
      end
      wchs_pkg::ST_HASH: begin
        if (st_i.hash_done) begin
          cmd_o.mod_start = 1'b1;
          state_d = wchs_pkg::ST_MOD;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      wchs_pkg::ST_MOD: begin
        if (st_i.mod_done) begin
          if (st_i.kind == wchs_pkg::KIND_ADD) begin
            cmd_o.probe_start = 1'b1;
            state_d = wchs_pkg::ST_PROBE_RD;
          end else begin
            state_d = wchs_pkg::ST_QSLOT;
          end
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      wchs_pkg::ST_QSLOT: begin
        if (!st_i.q_owner_nz) begin
          if (st_i.q_last) state_d = wchs_pkg::ST_DONE;
          else cmd_o.q_next = 1'b1;
        end else if (st_i.q_ovf) begin
          cmd_o.set_wanted = 1'b1;
          state_d = wchs_pkg::ST_DONE;
        end else begin
          cmd_o.probe_start = 1'b1;
          state_d = wchs_pkg::ST_PROBE_RD;
        end
      end
      wchs_pkg::ST_PROBE_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = wchs_pkg::ST_PROBE_CMP;
      end
      wchs_pkg::ST_PROBE_CMP: begin
        if (st_i.kind == wchs_pkg::KIND_ADD) begin
          if (st_i.rd_empty) begin
            cmd_o.insert = 1'b1;
            state_d = wchs_pkg::ST_DONE;
          end else if (st_i.rd_hit || st_i.n_last) begin
            state_d = wchs_pkg::ST_DONE;
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d = wchs_pkg::ST_PROBE_RD;
          end
        end else begin
          if (st_i.rd_hit && !st_i.rd_empty) begin
            cmd_o.set_wanted = 1'b1;
            state_d = wchs_pkg::ST_DONE;
          end else if (st_i.rd_empty || st_i.n_last) begin
            if (st_i.q_last) begin
              state_d = wchs_pkg::ST_DONE;
            end else begin
              cmd_o.q_next = 1'b1;
              state_d = wchs_pkg::ST_QSLOT;
            end
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d = wchs_pkg::ST_PROBE_RD;
          end
        end
      end
      wchs_pkg::ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (st_i.sweep_last) begin
          cmd_o.slot_clear = 1'b1;
          state_d = wchs_pkg::ST_DONE;
        end
      end
      wchs_pkg::ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = wchs_pkg::ST_IDLE;
        end
      end
      default: state_d = wchs_pkg::ST_INIT;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/wchs_dp.sv
// Datapath: FNV key unit, modulo unit, slot registers, key memory, result register.
`timescale 1ns / 1ps
`default_nettype none
module wchs_dp #(
  parameter int unsigned OWNER_SLOTS = wchs_pkg::OwnerSlotsDef,
  parameter int unsigned WANT_LIMIT  = wchs_pkg::WantLimitDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [1:0]        kind_i,
  input  wire  [7:0]        owner_id_i,
  input  wire  [255:0]      hash_i,       // word0 in the top bits
  input  wire  [63:0]       size_i,
  input  wire               out_ready_i,
  output logic              out_valid_o,
  output logic [3:0]        out_data_o,   // wanted, dropped, owner_overflow, idle
  input  wchs_pkg::cmd_t    cmd_i,
  output wchs_pkg::status_t st_o
);

  localparam int unsigned TBL    = 2 * WANT_LIMIT;
  localparam int unsigned IDX_W  = $clog2(TBL);
  localparam int unsigned CNT_W  = $clog2(WANT_LIMIT + 1);
  localparam int unsigned SLOT_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int unsigned DEPTH  = OWNER_SLOTS * TBL;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ProdW  = 2 * wchs_pkg::KeyW;
  localparam logic [ADDR_W-1:0] TblA  = ADDR_W'(TBL);
  localparam logic [IDX_W-1:0]  TblM1 = IDX_W'(TBL - 1);
  localparam logic [CNT_W-1:0]  LimC  = CNT_W'(WANT_LIMIT);
  localparam logic [wchs_pkg::KeyW-1:0] TblK  = wchs_pkg::KeyW'(TBL);
  // floor(2^32 / TBL): the quotient estimate is at most one short
  localparam logic [wchs_pkg::KeyW-1:0] Recip = wchs_pkg::KeyW'((64'd1 << 32) / TBL);

  // latched item
  wchs_pkg::kind_e kind_q;
  logic [7:0]      owner_q;
  logic [255:0]    hbuf_q;
  logic [63:0]     size_q;

  // per-slot state
  logic [7:0]       slot_own_q [OWNER_SLOTS];
  logic [CNT_W-1:0] slot_cnt_q [OWNER_SLOTS];
  logic             slot_ovf_q [OWNER_SLOTS];

  logic [SLOT_W-1:0] sel_q, pslot_q, qslot_q;
  logic              sel_vld_q;

  logic [wchs_pkg::KeyW-1:0] h_q, key, mkey_q, mix;
  logic [wchs_pkg::RndW-1:0] rnd_q, mcnt_q;
  logic [ProdW-1:0]          prod_q;
  logic [wchs_pkg::KeyW-1:0] r_q;
  logic [IDX_W-1:0]          j_q, n_q;
  logic [ADDR_W-1:0]         init_q, addr;

  logic [wchs_pkg::KeyW-1:0] mem [DEPTH];
  logic [wchs_pkg::KeyW-1:0] rdata_q;

  logic wanted_q, dropped_q, out_valid_q;
  logic [3:0] out_q;

  // owner lookup
  logic              found, free_any;
  logic [SLOT_W-1:0] fidx, fridx;
  logic              idle;

  always_comb begin
    found    = 1'b0;
    free_any = 1'b0;
    fidx     = '0;
    fridx    = '0;
    idle     = 1'b1;
    for (int s = OWNER_SLOTS - 1; s >= 0; s--) begin
      if (owner_q != '0 && slot_own_q[s] == owner_q) begin
        found = 1'b1;
        fidx  = SLOT_W'(s);
      end
      if (slot_own_q[s] == '0) begin
        free_any = 1'b1;
        fridx    = SLOT_W'(s);
      end
      if (slot_own_q[s] != '0 && (slot_cnt_q[s] != '0 || slot_ovf_q[s])) idle = 1'b0;
    end
  end

  assign key = (h_q == '0) ? wchs_pkg::KeyW'(1) : h_q;

  always_comb begin
    if (rnd_q < wchs_pkg::RndW'(wchs_pkg::ByteRounds)) mix = {24'd0, hbuf_q[255:248]};
    else if (rnd_q == wchs_pkg::RndW'(wchs_pkg::ByteRounds)) mix = size_q[31:0];
    else mix = size_q[63:32];
  end

  assign addr = ADDR_W'(pslot_q) * TblA + ADDR_W'(j_q);

  // item, hash and modulo registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= wchs_pkg::kind_e'(kind_i);
      owner_q <= owner_id_i;
      hbuf_q  <= hash_i;
      size_q  <= size_i;
      h_q     <= wchs_pkg::FnvBasis;
      rnd_q   <= '0;
    end else if (cmd_i.hash_step) begin
      h_q    <= (h_q ^ mix) * wchs_pkg::FnvPrime;
      hbuf_q <= {hbuf_q[247:0], 8'd0};
      rnd_q  <= rnd_q + 1'b1;
    end
    if (cmd_i.mod_start) begin
      mkey_q <= key;
      mcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      mcnt_q <= mcnt_q + 1'b1;
      case (mcnt_q)
        wchs_pkg::RndW'(0): prod_q <= ProdW'(mkey_q) * ProdW'(Recip);
        wchs_pkg::RndW'(1): r_q <= mkey_q - prod_q[ProdW-1:wchs_pkg::KeyW] * TblK;
        default:            r_q <= (r_q >= TblK) ? r_q - TblK : r_q;
      endcase
    end
  end

  // probe and sweep pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) sel_q <= found ? fidx : fridx;
    if (cmd_i.sweep_start) begin
      pslot_q <= fidx;
      j_q     <= '0;
    end else if (cmd_i.probe_start) begin
      pslot_q <= (kind_q == wchs_pkg::KIND_ADD) ? sel_q : qslot_q;
      j_q     <= r_q[IDX_W-1:0];
      n_q     <= '0;
    end else if (cmd_i.probe_adv) begin
      j_q <= (j_q == TblM1) ? '0 : j_q + 1'b1;
      n_q <= n_q + 1'b1;
    end else if (cmd_i.sweep_wr) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.q_start) qslot_q <= '0;
    else if (cmd_i.q_next) qslot_q <= qslot_q + 1'b1;
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) mem[init_q] <= '0;
    else if (cmd_i.sweep_wr) mem[addr] <= '0;
    else if (cmd_i.insert) mem[addr] <= key;
    if (cmd_i.mem_rd) rdata_q <= mem[addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      sel_vld_q   <= 1'b0;
      wanted_q    <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int s = 0; s < OWNER_SLOTS; s++) begin
        slot_own_q[s] <= '0;
        slot_cnt_q[s] <= '0;
        slot_ovf_q[s] <= 1'b0;
      end
    end else begin
      if (cmd_i.init_wr) init_q <= init_q + 1'b1;
      if (cmd_i.load) begin
        wanted_q  <= 1'b0;
        dropped_q <= 1'b0;
        sel_vld_q <= 1'b0;
      end
      if (cmd_i.resolve) begin
        sel_vld_q <= found || (kind_q == wchs_pkg::KIND_ADD && owner_q != '0 && free_any);
        if (kind_q == wchs_pkg::KIND_ADD && owner_q != '0 && !found && free_any) begin
          slot_own_q[fridx] <= owner_q;
          slot_cnt_q[fridx] <= '0;
          slot_ovf_q[fridx] <= 1'b0;
        end
      end
      if (cmd_i.set_dropped) dropped_q <= 1'b1;
      if (cmd_i.set_wanted)  wanted_q  <= 1'b1;
      if (cmd_i.set_ovf)     slot_ovf_q[fidx] <= 1'b1;
      if (cmd_i.insert)      slot_cnt_q[sel_q] <= slot_cnt_q[sel_q] + 1'b1;
      if (cmd_i.slot_clear) begin
        slot_cnt_q[pslot_q] <= '0;
        slot_ovf_q[pslot_q] <= 1'b0;
        if (kind_q == wchs_pkg::KIND_RELEASE) slot_own_q[pslot_q] <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        out_q <= {idle,
                  (kind_q == wchs_pkg::KIND_ADD) && sel_vld_q && slot_ovf_q[sel_q],
                  dropped_q, wanted_q};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    st_o            = '0;
    st_o.kind       = kind_q;
    st_o.owner_nz   = owner_q != '0;
    st_o.found      = found;
    st_o.free_any   = free_any;
    st_o.sel_ovf    = found && slot_ovf_q[fidx];
    st_o.sel_full   = found && (slot_cnt_q[fidx] >= LimC);
    st_o.hash_done  = rnd_q == wchs_pkg::RndW'(wchs_pkg::HashRounds);
    st_o.mod_done   = mcnt_q == wchs_pkg::RndW'(wchs_pkg::ModSteps);
    st_o.q_owner_nz = slot_own_q[qslot_q] != '0;
    st_o.q_ovf      = slot_ovf_q[qslot_q];
    st_o.q_last     = qslot_q == SLOT_W'(OWNER_SLOTS - 1);
    st_o.rd_empty   = rdata_q == '0;
    st_o.rd_hit     = rdata_q == key;
    st_o.n_last     = n_q == TblM1;
    st_o.sweep_last = j_q == TblM1;
    st_o.init_last  = init_q == ADDR_W'(DEPTH - 1);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

>>> hdl/wanted_content_hash_set_top.sv
// Top level: wanted-content hash set with stream ports.
//
//  channel | dir | tdata                               | tuser
//  s_axis  | in  | owner_id, hash_word0..3, size (328) | kind (2)
//  m_axis  | out | wanted, dropped, owner_overflow,    | -
//          |     | idle, zero pad (8)                  |
//
// Steps: an add or query runs 34 FNV rounds on one 32x32 multiplier, then
// a key-mod-table reduction (reciprocal multiply, multiply back and subtract,
// one correcting subtract), then a registered memory read and a compare per
// probed entry. A query walks the bound sets in slot order until a hit or an
// overflowed set. Clear and release sweep their set's 2*WANT_LIMIT entries.
// Reset: a pass zeroes all OWNER_SLOTS*2*WANT_LIMIT key memory words, with
// s_axis_tready_o low. Stalls: the result register holds an item while the
// next item is taken and processed.
`timescale 1ns / 1ps
`default_nettype none
module wanted_content_hash_set_top #(
  parameter int unsigned OWNER_SLOTS = wchs_pkg::OwnerSlotsDef,
  parameter int unsigned WANT_LIMIT  = wchs_pkg::WantLimitDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] owner_id, [71:8] hash_word0, [135:72] hash_word1,
  // [199:136] hash_word2, [263:200] hash_word3, [327:264] content_size
  input  wire  [327:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire  [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // [0] wanted, [1] dropped, [2] owner_overflow, [3] idle, [7:4] zero
  output logic [7:0]   m_axis_tdata_o
);

  wchs_pkg::cmd_t    cmd;
  wchs_pkg::status_t st;
  logic [3:0]        res;

  wchs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // hash words go in with word0 on top so bytes leave in order
  wchs_dp #(
    .OWNER_SLOTS (OWNER_SLOTS),
    .WANT_LIMIT  (WANT_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (s_axis_tuser_i),
    .owner_id_i  (s_axis_tdata_i[7:0]),
    .hash_i      ({s_axis_tdata_i[71:8], s_axis_tdata_i[135:72],
                   s_axis_tdata_i[199:136], s_axis_tdata_i[263:200]}),
    .size_i      (s_axis_tdata_i[327:264]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (res),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  assign m_axis_tdata_o = {4'd0, res};

endmodule
`default_nettype wire
